@@ rtl/core/bucketed_delta_pointer_encoder_defines.svh @@
// ----------------------------------------------------------------------------
// Bucketed delta pointer encoder: assertion macros
// Clocked assertion wrappers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef BUCKETED_DELTA_POINTER_ENCODER_DEFINES_SVH
`define BUCKETED_DELTA_POINTER_ENCODER_DEFINES_SVH

`ifndef SYNTHESIS
`define BDPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BDPE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BDPE_ASSERT(lbl, prop, msg)
`define BDPE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ rtl/core/bdpe_pkg.sv @@
// ----------------------------------------------------------------------------
// Bucketed delta pointer encoder package
// Shared widths, register map, reset values and the config and result types.
// ----------------------------------------------------------------------------
package bdpe_pkg;

  localparam int unsigned DataW      = 32;
  localparam int unsigned CodeW      = 8;
  localparam int unsigned PtrBitsDef = 32;
  localparam int unsigned AddrW      = 4;
  localparam int unsigned ApbW       = 32;

  localparam logic [CodeW-1:0] BucketSizeRst = 8'd64;
  localparam logic [DataW-1:0] EorMarkerRst  = 32'h8000_0000;
  localparam logic             MergeEorRst   = 1'b0;
  localparam logic [CodeW-1:0] EorCodeRst    = 8'd0;

  typedef enum logic [1:0] {
    RegBucketSize = 2'd0,
    RegEorMarker  = 2'd1,
    RegMergeEor   = 2'd2,
    RegEorCode    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [CodeW-1:0] bkt_items;
    logic [DataW-1:0] eor_marker;
    logic             merge_eor;
    logic [CodeW-1:0] eor_code;
  } cfg_t;

  typedef struct packed {
    logic [DataW-1:0] bucket_pool_index;
    logic             bucket_start;
    logic [DataW-1:0] pool_value;
    logic             pool_write;
    logic [CodeW-1:0] code_byte;
  } result_t;

endpackage

@@ rtl/core/bdpe_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file for bucket size, end-of-record marker, merge flag and code.
// ----------------------------------------------------------------------------
module bdpe_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bdpe_pkg::AddrW-1:0]  paddr,
  input  logic [bdpe_pkg::ApbW-1:0]   pwdata,
  output logic [bdpe_pkg::ApbW-1:0]   prdata,
  output logic                        pready,
  output bdpe_pkg::cfg_t              cfg
);

  bdpe_pkg::cfg_t     cfg_r;
  bdpe_pkg::cfg_t     cfg_nxt;
  bdpe_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx    = bdpe_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        bdpe_pkg::RegBucketSize: cfg_nxt.bkt_items  = pwdata[7:0];
        bdpe_pkg::RegEorMarker:  cfg_nxt.eor_marker = pwdata[31:0];
        bdpe_pkg::RegMergeEor:   cfg_nxt.merge_eor  = pwdata[0];
        bdpe_pkg::RegEorCode:    cfg_nxt.eor_code   = pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      bdpe_pkg::RegBucketSize: prdata = 32'(cfg_r.bkt_items);
      bdpe_pkg::RegEorMarker:  prdata = cfg_r.eor_marker;
      bdpe_pkg::RegMergeEor:   prdata = 32'(cfg_r.merge_eor);
      bdpe_pkg::RegEorCode:    prdata = 32'(cfg_r.eor_code);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bkt_items  <= bdpe_pkg::BucketSizeRst;
      cfg_r.eor_marker <= bdpe_pkg::EorMarkerRst;
      cfg_r.merge_eor  <= bdpe_pkg::MergeEorRst;
      cfg_r.eor_code   <= bdpe_pkg::EorCodeRst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ rtl/core/bdpe_encoder.sv @@
// ----------------------------------------------------------------------------
// Pointer encoder stage
// Codes one registered pointer against the running bucket state and loads
// the result register.
// ----------------------------------------------------------------------------
`include "bucketed_delta_pointer_encoder_defines.svh"

module bdpe_encoder #(
  parameter int unsigned POINTER_BITS = bdpe_pkg::PtrBitsDef
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bdpe_pkg::cfg_t               cfg,
  input  logic                         item_valid,
  input  logic [bdpe_pkg::DataW-1:0]   item_data,
  input  logic                         res_ready,
  output logic                         advance,
  output logic                         res_valid,
  output bdpe_pkg::result_t            res
);

  logic [POINTER_BITS-1:0]        prev_r;
  logic [POINTER_BITS-1:0]        prev_nxt;
  logic [bdpe_pkg::CodeW-1:0]     pos_r;
  logic [bdpe_pkg::CodeW-1:0]     pos_nxt;
  logic [bdpe_pkg::CodeW-1:0]     ovf_cnt_r;
  logic [bdpe_pkg::CodeW-1:0]     ovf_cnt_nxt;
  logic                           anch_r;
  logic                           anch_nxt;
  logic [bdpe_pkg::DataW-1:0]     pool_cnt_r;
  logic [bdpe_pkg::DataW-1:0]     pool_cnt_nxt;
  logic                           res_valid_r;
  logic                           res_valid_nxt;
  bdpe_pkg::result_t              res_r;
  bdpe_pkg::result_t              res_nxt;

  logic [POINTER_BITS-1:0]        cur_ptr;
  logic [bdpe_pkg::DataW-1:0]     cur;
  logic [bdpe_pkg::DataW-1:0]     prev;
  logic [bdpe_pkg::DataW-1:0]     diff;
  logic [bdpe_pkg::CodeW-1:0]     size;
  logic [bdpe_pkg::CodeW-1:0]     maxd;
  logic [bdpe_pkg::CodeW-1:0]     ovf_inc;
  logic                           start;
  logic                           last;
  logic                           is_eor;
  logic                           is_ovf;

  assign advance   = item_valid && (!res_valid_r || res_ready);
  assign res_valid = res_valid_r;
  assign res       = res_r;

  assign cur_ptr = item_data[POINTER_BITS-1:0];
  assign cur     = bdpe_pkg::DataW'(cur_ptr);
  assign prev    = bdpe_pkg::DataW'(prev_r);
  assign diff    = cur - prev;
  assign size    = (cfg.bkt_items == '0) ? 8'd1 : cfg.bkt_items;
  assign maxd    = 8'd255 - size;
  assign ovf_inc = ovf_cnt_r + 8'd1;
  assign start   = (pos_r == '0);
  assign last    = ({1'b0, pos_r} + 9'd1) >= {1'b0, size};
  assign is_eor  = (cur == cfg.eor_marker) || (cfg.merge_eor && (cur > cfg.eor_marker));
  assign is_ovf  = (cur <= prev) || (diff > bdpe_pkg::DataW'(maxd)) || (last && !anch_r);

  always_comb begin
    prev_nxt      = prev_r;
    pos_nxt       = pos_r;
    ovf_cnt_nxt   = ovf_cnt_r;
    anch_nxt      = anch_r;
    pool_cnt_nxt  = pool_cnt_r;
    res_nxt       = res_r;
    res_valid_nxt = res_valid_r && !res_ready;

    if (advance) begin
      res_valid_nxt             = 1'b1;
      res_nxt.bucket_start      = start;
      res_nxt.bucket_pool_index = start ? pool_cnt_r : '0;
      res_nxt.pool_write        = 1'b0;
      res_nxt.pool_value        = '0;
      prev_nxt                  = cur_ptr;

      priority if (is_eor) begin
        res_nxt.code_byte = cfg.eor_code;
        anch_nxt          = 1'b1;
      end else if (is_ovf) begin
        ovf_cnt_nxt        = ovf_inc;
        res_nxt.code_byte  = maxd + ovf_inc;
        res_nxt.pool_write = 1'b1;
        res_nxt.pool_value = cur;
        pool_cnt_nxt       = pool_cnt_r + 32'd1;
        anch_nxt           = 1'b1;
      end else begin
        res_nxt.code_byte = diff[7:0];
      end

      if (last) begin
        pos_nxt     = '0;
        ovf_cnt_nxt = '0;
        anch_nxt    = 1'b0;
      end else begin
        pos_nxt = pos_r + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      pos_r       <= '0;
      ovf_cnt_r   <= '0;
      anch_r      <= 1'b0;
      pool_cnt_r  <= '0;
      res_valid_r <= 1'b0;
    end else begin
      prev_r      <= prev_nxt;
      pos_r       <= pos_nxt;
      ovf_cnt_r   <= ovf_cnt_nxt;
      anch_r      <= anch_nxt;
      pool_cnt_r  <= pool_cnt_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  `BDPE_ASSERT(a_pool_cnt_step, (advance && res_nxt.pool_write) |=> (pool_cnt_r == $past(pool_cnt_r) + 32'd1), "pool count did not step on a pool write")
  `BDPE_ASSERT(a_pool_cnt_hold, (!advance || !res_nxt.pool_write) |=> $stable(pool_cnt_r), "pool count moved without a pool write")
  `BDPE_ASSERT(a_bucket_close, (advance && last) |=> (pos_r == '0 && ovf_cnt_r == '0 && !anch_r), "bucket state not cleared at bucket close")
  `BDPE_ASSERT(a_ovf_anchored, (ovf_cnt_r != '0) |-> anch_r, "overflow counted in an unanchored bucket")

endmodule

@@ rtl/core/bucketed_delta_pointer_encoder.sv @@
// ----------------------------------------------------------------------------
// Bucketed delta pointer encoder
// Turns a stream of successor pointers into one code byte per pointer.
// ----------------------------------------------------------------------------
// Input channel in_*: one successor pointer per item in in_tdata.
// Output channel out_*: one result item per input item, in order, carrying
// the code byte, the absolute pointer for the pool when one is written, and
// the pool entry count at the start of each bucket.
// Config port cfg_*: APB-style, registers at byte addresses 0 (bucket size),
// 4 (end-of-record marker), 8 (merge flag), 12 (end-of-record code).
// Write the registers only while no item is in flight.
// Path: an item accepted on in_* passes through the input register and then
// the result register before it is on out_*.
// Throughput: one item per cycle while out_tready is high; the only loop is the
// previous pointer and bucket counters, updated by the encoder stage per item.
// Reset: the previous pointer, bucket position, overflow count, anchor flag
// and pool count clear to zero; registers take their reset values.
// Stall: while out_tready is low the result holds, the input register fills,
// and in_tready drops only once both registers hold an item.
// ----------------------------------------------------------------------------
module bucketed_delta_pointer_encoder #(
  parameter int unsigned POINTER_BITS = bdpe_pkg::PtrBitsDef
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [31:0]                 in_tdata,     // [31:0] successor
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [71:0]                 out_tdata,    // [7:0] code_byte, [39:8] pool_value,
                                                    // [71:40] bucket_pool_index
  output logic [1:0]                  out_tuser,    // [0] pool_write, [1] bucket_start
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [bdpe_pkg::AddrW-1:0]  cfg_paddr,
  input  logic [bdpe_pkg::ApbW-1:0]   cfg_pwdata,
  output logic [bdpe_pkg::ApbW-1:0]   cfg_prdata,
  output logic                        cfg_pready
);

  bdpe_pkg::cfg_t             cfg;
  bdpe_pkg::result_t          res;
  logic                       advance;
  logic                       in_valid_r;
  logic                       in_valid_nxt;
  logic [bdpe_pkg::DataW-1:0] in_data_r;
  logic [bdpe_pkg::DataW-1:0] in_data_nxt;
  logic                       in_accept;

  assign in_tready = !in_valid_r || advance;
  assign in_accept = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    in_data_nxt  = in_data_r;
    if (in_accept) begin
      in_valid_nxt = 1'b1;
      in_data_nxt  = in_tdata;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_data_r <= in_data_nxt;
  end

  bdpe_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  bdpe_encoder #(
    .POINTER_BITS (POINTER_BITS)
  ) u_encoder (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (in_valid_r),
    .item_data  (in_data_r),
    .res_ready  (out_tready),
    .advance    (advance),
    .res_valid  (out_tvalid),
    .res        (res)
  );

  assign out_tdata = {res.bucket_pool_index, res.pool_value, res.code_byte};
  assign out_tuser = {res.bucket_start, res.pool_write};

endmodule

@@ tb/sv/bdpe_stream_checker.sv @@
// ----------------------------------------------------------------------------
// Bucketed delta pointer encoder: stream checker
// Watches the input, result and register ports of the encoder, works out the
// code byte, pool entry and bucket report for each accepted successor, and
// compares every accepted result item field by field with the oldest one due.
// ----------------------------------------------------------------------------
module bdpe_stream_checker
  import bdpe_pkg::*;
#(
  parameter int unsigned PtrBits = PtrBitsDef
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [31:0]      in_tdata,     // [31:0] successor
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [71:0]      out_tdata,    // [7:0] code_byte, [39:8] pool_value,
                                         // [71:40] bucket_pool_index
  input  logic [1:0]       out_tuser,    // [0] pool_write, [1] bucket_start
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [AddrW-1:0] cfg_paddr,
  input  logic [ApbW-1:0]  cfg_pwdata,
  input  logic             cfg_pready,
  output int               error_count,
  output int               codes_in_flight
);

  localparam logic [31:0] PtrMask = 32'((64'd1 << PtrBits) - 64'd1);

  cfg_t        regs;
  logic [31:0] prev_ptr;
  logic [7:0]  bucket_pos;
  logic [7:0]  overflow_cnt;
  logic        anchored;
  logic [31:0] pool_entries;
  result_t     expected_codes[$];

  function automatic result_t encode_successor(input logic [31:0] raw);
    result_t     r;
    logic [31:0] cur;
    logic [7:0]  size;
    logic [7:0]  max_delta;
    logic        is_last;
    cur       = raw & PtrMask;
    size      = (regs.bkt_items == 8'd0) ? 8'd1 : regs.bkt_items;
    max_delta = 8'd255 - size;
    is_last   = ({1'b0, bucket_pos} + 9'd1) >= {1'b0, size};
    r = '0;
    r.bucket_start      = (bucket_pos == 8'd0);
    r.bucket_pool_index = r.bucket_start ? pool_entries : 32'd0;
    if (cur == regs.eor_marker || (cur > regs.eor_marker && regs.merge_eor)) begin
      r.code_byte = regs.eor_code;
      anchored    = 1'b1;
    end else if (cur <= prev_ptr || (cur - prev_ptr) > {24'd0, max_delta} ||
                 (is_last && !anchored)) begin
      overflow_cnt = overflow_cnt + 8'd1;
      r.code_byte  = max_delta + overflow_cnt;
      r.pool_write = 1'b1;
      r.pool_value = cur;
      pool_entries = pool_entries + 32'd1;
      anchored     = 1'b1;
    end else begin
      r.code_byte = cur[7:0] - prev_ptr[7:0];
    end
    prev_ptr = cur;
    if (is_last) begin
      bucket_pos   = 8'd0;
      overflow_cnt = 8'd0;
      anchored     = 1'b0;
    end else begin
      bucket_pos = bucket_pos + 8'd1;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst_n) begin
      regs = '{bkt_items: BucketSizeRst, eor_marker: EorMarkerRst,
               merge_eor: MergeEorRst, eor_code: EorCodeRst};
      prev_ptr        = '0;
      bucket_pos      = '0;
      overflow_cnt    = '0;
      anchored        = 1'b0;
      pool_entries    = '0;
      expected_codes.delete();
      error_count     = 0;
      codes_in_flight = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.code_byte         = out_tdata[7:0];
        got.pool_value        = out_tdata[39:8];
        got.bucket_pool_index = out_tdata[71:40];
        got.pool_write        = out_tuser[0];
        got.bucket_start      = out_tuser[1];
        if (expected_codes.size() == 0) begin
          $error("result item with none due: code_byte 0x%0h", got.code_byte);
          error_count++;
        end else begin
          want = expected_codes.pop_front();
          check_field("code_byte", 32'(want.code_byte), 32'(got.code_byte));
          check_field("pool_write", 32'(want.pool_write), 32'(got.pool_write));
          check_field("pool_value", want.pool_value, got.pool_value);
          check_field("bucket_start", 32'(want.bucket_start), 32'(got.bucket_start));
          check_field("bucket_pool_index", want.bucket_pool_index,
                      got.bucket_pool_index);
        end
      end
      if (in_tvalid && in_tready) begin
        expected_codes.push_back(encode_successor(in_tdata));
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_idx_t'(cfg_paddr[AddrW-1:2]))
          RegBucketSize: regs.bkt_items  = cfg_pwdata[7:0];
          RegEorMarker:  regs.eor_marker = cfg_pwdata[31:0];
          RegMergeEor:   regs.merge_eor  = cfg_pwdata[0];
          RegEorCode:    regs.eor_code   = cfg_pwdata[7:0];
          default: ;
        endcase
      end
      codes_in_flight = expected_codes.size();
    end
  end

endmodule

@@ tb/sv/bucketed_delta_pointer_encoder_test.sv @@
// ----------------------------------------------------------------------------
// Bucketed delta pointer encoder: testbench top
// Drives directed and random successor streams through the encoder under a
// range of register settings and idle patterns, with a long output stall,
// and reports the verdict from the stream checker's error count.
// ----------------------------------------------------------------------------
module bucketed_delta_pointer_encoder_test;
  import bdpe_pkg::*;

  localparam int QuietLimit  = 2000;
  localparam int SegItems    = 193;
  localparam int StallCycles = 60;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [31:0]      in_tdata;     // [31:0] successor
  logic             out_tvalid;
  logic             out_tready;
  logic [71:0]      out_tdata;    // [7:0] code_byte, [39:8] pool_value,
                                  // [71:40] bucket_pool_index
  logic [1:0]       out_tuser;    // [0] pool_write, [1] bucket_start
  logic             cfg_psel;
  logic             cfg_penable;
  logic             cfg_pwrite;
  logic [AddrW-1:0] cfg_paddr;
  logic [ApbW-1:0]  cfg_pwdata;
  logic [ApbW-1:0]  cfg_prdata;
  logic             cfg_pready;

  int          error_count;
  int          codes_in_flight;
  int          snd_idle;
  int          rcv_idle;
  int          stall_left;
  bit          hold_req;
  int          quiet_cycles;
  logic [31:0] prev_sent;
  logic [7:0]  bs_now;
  logic [31:0] marker_now;

  bucketed_delta_pointer_encoder dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  bdpe_stream_checker code_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_pready      (cfg_pready),
    .error_count     (error_count),
    .codes_in_flight (codes_in_flight)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if (hold_req) begin
      hold_req   = 1'b0;
      stall_left = StallCycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("FAIL bucketed_delta_pointer_encoder");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic cfg_write(input reg_idx_t idx, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(input logic [7:0] bs, input logic [31:0] marker,
                            input logic merge, input logic [7:0] code);
    in_tvalid <= 1'b0;
    wait (codes_in_flight == 0);
    @(negedge clk);
    cfg_write(RegBucketSize, {24'd0, bs});
    cfg_write(RegEorMarker, marker);
    cfg_write(RegMergeEor, {31'd0, merge});
    cfg_write(RegEorCode, {24'd0, code});
    bs_now     = bs;
    marker_now = marker;
  endtask

  task automatic send_successor(input logic [31:0] v);
    while ($urandom_range(99) < snd_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    do @(posedge clk); while (!in_tready);
    prev_sent = v;
    @(negedge clk);
  endtask

  function automatic logic [31:0] next_successor();
    logic [7:0]  sz;
    logic [7:0]  max_delta;
    int unsigned pick;
    sz        = (bs_now == 8'd0) ? 8'd1 : bs_now;
    max_delta = 8'd255 - sz;
    pick      = $urandom_range(99);
    if (pick < 55) begin
      return prev_sent + ((max_delta == 8'd0) ? 32'd1 :
                          32'($urandom_range(32'(max_delta), 1)));
    end else if (pick < 63) begin
      return prev_sent + 32'(max_delta) + 32'($urandom_range(20, 1));
    end else if (pick < 70) begin
      return prev_sent;
    end else if (pick < 77) begin
      return prev_sent - 32'($urandom_range(1000, 1));
    end else if (pick < 85) begin
      return marker_now;
    end else if (pick < 90) begin
      return marker_now + 32'($urandom_range(50, 1));
    end
    return $urandom;
  endfunction

  initial begin
    logic [7:0]  seg_bs;
    logic [31:0] seg_marker;
    logic        seg_merge;
    logic [7:0]  seg_code;
    int          s;
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    stall_left  = 0;
    hold_req    = 1'b0;
    quiet_cycles = 0;
    prev_sent   = '0;
    bs_now      = BucketSizeRst;
    marker_now  = EorMarkerRst;
    snd_idle    = 37;
    rcv_idle    = 80;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_successor(32'd0);
    send_successor(32'd1);
    send_successor(32'd192);
    send_successor(32'd385);
    send_successor(32'd385);
    send_successor(32'd100);
    send_successor(32'h8000_0000);
    send_successor(32'h8000_0005);
    send_successor(32'hFFFF_FFFF);
    send_successor(32'hFFFF_FFFE);

    // bucket size zero, shrunk mid-bucket from the reset size
    set_config(8'd0, 32'd1000, 1'b1, 8'd255);
    send_successor(32'd5);
    send_successor(32'd6);
    send_successor(32'd1000);
    send_successor(32'd2000);
    send_successor(32'd999);

    // overflow code wraps once the bucket shrinks below the overflow count
    set_config(8'd64, 32'hFFFF_FFFF, 1'b0, 8'd7);
    send_successor(32'd998);
    set_config(8'd1, 32'hFFFF_FFFF, 1'b0, 8'd7);
    send_successor(32'd0);
    send_successor(32'd1);
    send_successor(32'hFFFF_FFFF);

    for (int phase = 0; phase < 3; phase++) begin
      snd_idle = (phase == 0) ? 37 : (phase == 1) ? 80 : 0;
      rcv_idle = (phase == 0) ? 80 : (phase == 1) ? 37 : 0;
      for (int seg = 0; seg < 3; seg++) begin
        s = phase * 3 + seg;
        case (s)
          0: seg_bs = 8'd1;
          1: seg_bs = 8'd254;
          2: seg_bs = 8'd0;
          3: seg_bs = 8'd255;
          4: seg_bs = 8'd64;
          default: seg_bs = 8'($urandom_range(16, 2));
        endcase
        case (s % 3)
          0: seg_marker = 32'hFFFF_FFFF;
          1: seg_marker = $urandom;
          default: seg_marker = 32'd0;
        endcase
        seg_merge = (s % 3 == 2) ? 1'b0 : s[0];
        seg_code  = (s == 0) ? 8'd0 : (s == 1) ? 8'd255 : 8'($urandom_range(255));
        set_config(seg_bs, seg_marker, seg_merge, seg_code);
        for (int n = 0; n < SegItems; n++) begin
          if (s == 0 && n == 40) hold_req = 1'b1;
          send_successor(next_successor());
        end
      end
    end

    in_tvalid <= 1'b0;
    wait (codes_in_flight == 0);
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS bucketed_delta_pointer_encoder");
    end else begin
      $display("FAIL bucketed_delta_pointer_encoder");
    end
    $finish;
  end

endmodule
